@@ rtl/ibss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibss_pkg
// shared types and constants of the imu burst sample scaler
// ----------------------------------------------------------------------------
package ibss_pkg;

  localparam int BURST_BYTES = 14;
  localparam int POS_W       = 4;

  // queue between the byte front end and the scaling pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic REG_ACCEL_FS = 1'b0;
  localparam logic REG_GYRO_FS  = 1'b1;

  // channel kinds
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_TEMP  = 2'd1;
  localparam logic [1:0] KIND_GYRO  = 2'd2;

  // channel numbers
  localparam logic [2:0] CHAN_ACCEL_X = 3'd0;
  localparam logic [2:0] CHAN_ACCEL_Z = 3'd2;
  localparam logic [2:0] CHAN_TEMP    = 3'd3;
  localparam logic [2:0] CHAN_GYRO_Z  = 3'd6;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         chan;
    logic               last;
    logic signed [15:0] raw;
  } sample_t;

endpackage

@@ rtl/imu_burst_sample_scaler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_burst_sample_scaler_top
// six-axis imu burst byte stream to raw and q15.16 scaled channel samples
// ----------------------------------------------------------------------------
// Takes one burst byte per item and keeps up with one item per clock cycle:
// the front end pairs each byte as it is taken and every stage behind it
// accepts a new sample each cycle. Bytes pair up high byte first into accel
// x/y/z, temperature and gyro x/y/z; every odd byte yields one result with
// the channel number, the raw sample and the scaled value in signed q15.16
// (g, deg/s or deg C). frame_start forces the byte to be byte 0 of a new
// burst; after byte 13 the position wraps on its own. A result passes through
// the sample queue and then all five stages of the scaling pipeline
// (coefficient products, reciprocal multiply, correction product, compare,
// sign and offset).
// in_ready drops only when the four-entry sample queue in front of that
// pipeline is full, which happens only while the result side is stalled.
// Range registers are written through cfg_write/cfg_index/cfg_data and
// should change only while idle.
// ----------------------------------------------------------------------------
module imu_burst_sample_scaler_top (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data,
  // byte input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  // sample output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         channel,
  output logic signed [15:0] raw_value,
  output logic signed [31:0] scaled_value,
  output logic               last_of_frame
);

  logic [1:0]        accel_fs_sel;
  logic [1:0]        gyro_fs_sel;
  logic              accept;
  logic              push;
  ibss_pkg::sample_t push_item;
  logic              queue_full;
  logic              pop;
  logic              pop_valid;
  ibss_pkg::sample_t pop_item;

  // range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_fs_sel <= '0;
      gyro_fs_sel  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ibss_pkg::REG_ACCEL_FS: accel_fs_sel <= cfg_data;
        ibss_pkg::REG_GYRO_FS:  gyro_fs_sel  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a byte item is taken whenever the queue has room
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // front end: byte position tracking and pairing
  ibss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .accept      (accept),
    .push        (push),
    .item        (push_item)
  );

  // decouples byte intake from the scaling pipeline
  ibss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // back end: scaling pipeline with output register
  ibss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pop_valid),
    .in_item       (pop_item),
    .in_ready      (pop),
    .accel_fs_sel  (accel_fs_sel),
    .gyro_fs_sel   (gyro_fs_sel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel       (channel),
    .raw_value     (raw_value),
    .scaled_value  (scaled_value),
    .last_of_frame (last_of_frame)
  );

endmodule

@@ rtl/ibss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibss_front
// pairs burst bytes into raw samples and tags each with its channel kind
// ----------------------------------------------------------------------------
module ibss_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  logic              frame_start,
  input  logic              accept,
  output logic              push,
  output ibss_pkg::sample_t item
);

  logic [ibss_pkg::POS_W-1:0] byte_position;
  logic [ibss_pkg::POS_W-1:0] byte_position_next;
  logic [ibss_pkg::POS_W-1:0] pos;
  logic [ibss_pkg::POS_W-1:0] pos_inc;
  logic [7:0]                 high_byte_latch;

  always_comb begin
    // frame start or an impossible position restarts the burst
    if (frame_start || byte_position >= ibss_pkg::POS_W'(ibss_pkg::BURST_BYTES)) begin
      pos = '0;
    end else begin
      pos = byte_position;
    end
    pos_inc = pos + 1'b1;
    if (pos_inc >= ibss_pkg::POS_W'(ibss_pkg::BURST_BYTES)) begin
      byte_position_next = '0;
    end else begin
      byte_position_next = pos_inc;
    end
  end

  always_comb begin
    item.chan = pos[3:1];
    item.raw  = {high_byte_latch, data_byte};
    item.last = (pos[3:1] == ibss_pkg::CHAN_GYRO_Z);
    unique case (pos[3:1]) inside
      [ibss_pkg::CHAN_ACCEL_X:ibss_pkg::CHAN_ACCEL_Z]: item.kind = ibss_pkg::KIND_ACCEL;
      ibss_pkg::CHAN_TEMP:                             item.kind = ibss_pkg::KIND_TEMP;
      default:                                         item.kind = ibss_pkg::KIND_GYRO;
    endcase
  end

  // odd byte completes a pair
  assign push = accept && pos[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      high_byte_latch <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      if (!pos[0]) begin
        high_byte_latch <= data_byte;
      end
    end
  end

endmodule

@@ rtl/ibss_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibss_queue
// short sample queue between the front end and the scaling pipeline
// ----------------------------------------------------------------------------
module ibss_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ibss_pkg::sample_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output ibss_pkg::sample_t pop_item
);

  ibss_pkg::sample_t            entries [ibss_pkg::QUEUE_DEPTH];
  logic [ibss_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ibss_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ibss_pkg::QCNT_W-1:0]  count;
  logic                         do_pop;

  assign full      = (count == ibss_pkg::QCNT_W'(ibss_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ibss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibss_back
// five stage scaling pipeline: constant division by reciprocal with correction
// ----------------------------------------------------------------------------
module ibss_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ibss_pkg::sample_t  in_item,
  output logic               in_ready,
  input  logic [1:0]         accel_fs_sel,
  input  logic [1:0]         gyro_fs_sel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         channel,
  output logic signed [15:0] raw_value,
  output logic signed [31:0] scaled_value,
  output logic               last_of_frame
);

  // round(mag*M/D) = mag*(M/D) + floor((mag*(M%D) + D/2) / D)
  localparam int TEMP_M  = 16384;
  localparam int TEMP_D  = 85;
  localparam int GYRO0_M = 65536;
  localparam int GYRO1_M = 131072;
  localparam int GYRO2_M = 81920;
  localparam int GYRO3_M = 163840;
  localparam int GYRO_DA = 131;
  localparam int GYRO_DB = 41;

  localparam logic [11:0] TEMP_QM  = 12'(TEMP_M / TEMP_D);
  localparam logic [11:0] GYRO0_QM = 12'(GYRO0_M / GYRO_DA);
  localparam logic [11:0] GYRO1_QM = 12'(GYRO1_M / GYRO_DA);
  localparam logic [11:0] GYRO2_QM = 12'(GYRO2_M / GYRO_DB);
  localparam logic [11:0] GYRO3_QM = 12'(GYRO3_M / GYRO_DB);
  localparam logic [6:0]  TEMP_RM  = 7'(TEMP_M % TEMP_D);
  localparam logic [6:0]  GYRO0_RM = 7'(GYRO0_M % GYRO_DA);
  localparam logic [6:0]  GYRO1_RM = 7'(GYRO1_M % GYRO_DA);
  localparam logic [6:0]  GYRO2_RM = 7'(GYRO2_M % GYRO_DB);
  localparam logic [6:0]  GYRO3_RM = 7'(GYRO3_M % GYRO_DB);
  localparam logic [26:0] RECIP_T  = 27'((64'd1 << 32) / TEMP_D);
  localparam logic [26:0] RECIP_A  = 27'((64'd1 << 32) / GYRO_DA);
  localparam logic [26:0] RECIP_B  = 27'((64'd1 << 32) / GYRO_DB);

  localparam logic signed [31:0] TEMP_OFFSET = 32'sd2394030;

  typedef struct packed {
    logic [11:0] qm;
    logic [6:0]  rm;
    logic [7:0]  den;
    logic [26:0] recip;
  } coef_t;

  coef_t       coef;
  logic [15:0] raw_u;
  logic [15:0] mag0;

  // stage registers
  logic              v1, v2, v3, v4, v5;
  logic              en1, en2, en3, en4, en5;
  ibss_pkg::sample_t s1, s2, s3, s4;
  logic [22:0]       y1, y2, y3;
  logic [27:0]       p1, p2, p3;
  logic [26:0]       recip1;
  logic [7:0]        den1, den2, den3;
  logic [17:0]       q0_2, q0_3;
  logic [25:0]       qd3;
  logic [27:0]       mag4;

  logic [49:0]        prod2;
  logic [22:0]        rem4;
  logic [17:0]        q4;
  logic signed [31:0] smag5;
  logic signed [31:0] result5;
  logic [2:0]         shamt;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v5;

  always_comb begin
    coef = '0;
    if (in_item.kind == ibss_pkg::KIND_TEMP) begin
      coef = '{qm: TEMP_QM, rm: TEMP_RM, den: 8'(TEMP_D), recip: RECIP_T};
    end else if (in_item.kind == ibss_pkg::KIND_GYRO) begin
      case (gyro_fs_sel)
        2'd0:    coef = '{qm: GYRO0_QM, rm: GYRO0_RM, den: 8'(GYRO_DA), recip: RECIP_A};
        2'd1:    coef = '{qm: GYRO1_QM, rm: GYRO1_RM, den: 8'(GYRO_DA), recip: RECIP_A};
        2'd2:    coef = '{qm: GYRO2_QM, rm: GYRO2_RM, den: 8'(GYRO_DB), recip: RECIP_B};
        default: coef = '{qm: GYRO3_QM, rm: GYRO3_RM, den: 8'(GYRO_DB), recip: RECIP_B};
      endcase
    end
  end

  assign raw_u = in_item.raw;
  assign mag0  = in_item.raw[15] ? (~raw_u + 16'd1) : raw_u;

  assign prod2 = 50'(y1) * 50'(recip1);
  assign rem4  = y3 - 23'(qd3);
  assign q4    = q0_3 + 18'(rem4 >= 23'(den3));
  assign smag5 = s4.raw[15] ? -$signed({4'd0, mag4}) : $signed({4'd0, mag4});
  assign shamt = {1'b0, accel_fs_sel} + 3'd2;

  always_comb begin
    case (s4.kind)
      ibss_pkg::KIND_ACCEL: result5 = 32'(s4.raw) <<< shamt;
      ibss_pkg::KIND_TEMP:  result5 = smag5 + TEMP_OFFSET;
      default:              result5 = smag5;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1     <= in_item;
      y1     <= 23'(mag0) * 23'(coef.rm) + 23'(coef.den >> 1);
      p1     <= 28'(mag0) * 28'(coef.qm);
      recip1 <= coef.recip;
      den1   <= coef.den;
    end
    if (en2) begin
      s2   <= s1;
      y2   <= y1;
      p2   <= p1;
      den2 <= den1;
      q0_2 <= prod2[49:32];
    end
    if (en3) begin
      s3   <= s2;
      y3   <= y2;
      p3   <= p2;
      den3 <= den2;
      q0_3 <= q0_2;
      qd3  <= 26'(q0_2) * 26'(den2);
    end
    if (en4) begin
      s4   <= s3;
      mag4 <= p3 + 28'(q4);
    end
    if (en5) begin
      channel       <= s4.chan;
      raw_value     <= s4.raw;
      last_of_frame <= s4.last;
      scaled_value  <= result5;
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the imu burst sample scaler
// ----------------------------------------------------------------------------
// Feeds burst bytes through the valid/ready byte port and tracks the burst
// position and pending high byte on the side, so that every odd byte gives
// an expected channel, raw sample and q15.16 scaled value. Results are
// matched in order against that list as they leave the block. Directed
// items cover the field extremes, the wrap after byte 13 and a frame start
// in the middle of a pair. Random phases then run under different range
// settings, mostly with random idle bursts on either side, and a final
// phase runs without any idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  CLK_PERIOD       = 8;
  localparam int  RESET_CYCLES     = 12;
  localparam int  DRAIN_CYCLES     = 12;   // a bit over the five-stage scaling pipe
  localparam int  CYCLE_LIMIT      = 300000;
  localparam int  REPORT_MAX       = 10;
  localparam int  PHASE_ITEMS      = 110;
  localparam int  TAIL_ITEMS       = 84;
  localparam longint TEMP_OFFSET_Q16 = 2394030;  // round(36.53 * 65536)

  // full-scale range codes
  localparam logic [1:0] ACCEL_2G    = 2'd0;
  localparam logic [1:0] ACCEL_4G    = 2'd1;
  localparam logic [1:0] ACCEL_8G    = 2'd2;
  localparam logic [1:0] ACCEL_16G   = 2'd3;
  localparam logic [1:0] GYRO_250DPS  = 2'd0;
  localparam logic [1:0] GYRO_500DPS  = 2'd1;
  localparam logic [1:0] GYRO_1000DPS = 2'd2;
  localparam logic [1:0] GYRO_2000DPS = 2'd3;

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [15:0] raw;
    logic signed [31:0] scaled;
    logic               last;
  } sample_rec_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [1:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               frame_start;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         channel;
  logic signed [15:0] raw_value;
  logic signed [31:0] scaled_value;
  logic               last_of_frame;

  // shadow of the block's state and range registers
  logic [1:0] accel_sel;
  logic [1:0] gyro_sel;
  int         burst_pos;
  logic [7:0] high_byte;

  sample_rec_t pending_samples[$];
  int          mismatches;
  int          cycle_count;

  // idle knobs, changed per phase
  bit in_gaps_on;
  bit out_stalls_on;

  imu_burst_sample_scaler_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel       (channel),
    .raw_value     (raw_value),
    .scaled_value  (scaled_value),
    .last_of_frame (last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // round to nearest, ties away from zero; den is positive
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // physical value in q15.16 for one channel under the current ranges
  function automatic logic signed [31:0] scale_sample(input logic [2:0] chan,
                                                      input logic signed [15:0] raw);
    longint r;
    longint v;
    r = raw;
    if (chan <= ibss_pkg::CHAN_ACCEL_Z) begin
      case (accel_sel)
        ACCEL_2G:  v = r * 4;
        ACCEL_4G:  v = r * 8;
        ACCEL_8G:  v = r * 16;
        default:   v = r * 32;
      endcase
    end else if (chan == ibss_pkg::CHAN_TEMP) begin
      v = round_div(r * 16384, 85) + TEMP_OFFSET_Q16;
    end else begin
      case (gyro_sel)
        GYRO_250DPS:  v = round_div(r * 65536, 131);
        GYRO_500DPS:  v = round_div(r * 131072, 131);
        GYRO_1000DPS: v = round_div(r * 81920, 41);
        default:      v = round_div(r * 163840, 41);
      endcase
    end
    return v[31:0];
  endfunction

  // advance the burst tracker by one accepted byte; odd bytes queue a sample
  task automatic track_burst_byte(input logic [7:0] b, input logic start);
    int          pos;
    sample_rec_t rec;
    pos = (start || burst_pos >= ibss_pkg::BURST_BYTES) ? 0 : burst_pos;
    burst_pos = (pos + 1 >= ibss_pkg::BURST_BYTES) ? 0 : pos + 1;
    if (pos % 2 == 0) begin
      high_byte = b;
    end else begin
      rec.chan   = 3'(pos / 2);
      rec.raw    = {high_byte, b};
      rec.scaled = scale_sample(rec.chan, rec.raw);
      rec.last   = (rec.chan == ibss_pkg::CHAN_GYRO_Z);
      pending_samples.push_back(rec);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking, sampled at the falling edge where everything is settled
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(negedge clk) begin : check_results
    sample_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        note_mismatch($sformatf("unexpected result chan %0d raw %0d scaled %0d",
                                channel, raw_value, scaled_value));
      end else begin
        want = pending_samples.pop_front();
        if (channel !== want.chan || raw_value !== want.raw ||
            scaled_value !== want.scaled || last_of_frame !== want.last)
          note_mismatch($sformatf(
            "expected chan %0d raw %0d scaled %0d last %0d, got %0d %0d %0d %0d",
            want.chan, want.raw, want.scaled, want.last,
            channel, raw_value, scaled_value, last_of_frame));
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one byte item; valid stays up between back-to-back items
  task automatic send_byte(input logic [7:0] b, input logic start);
    bit taken;
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    frame_start <= start;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    track_burst_byte(b, start);
  endtask

  // wait until every queued sample has come out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both range registers, written back to back while idle
  task automatic set_ranges(input logic [1:0] accel, input logic [1:0] gyro);
    cfg_write <= 1'b1;
    cfg_index <= ibss_pkg::REG_ACCEL_FS;
    cfg_data  <= accel;
    @(posedge clk);
    cfg_index <= ibss_pkg::REG_GYRO_FS;
    cfg_data  <= gyro;
    @(posedge clk);
    cfg_write <= 1'b0;
    accel_sel = accel;
    gyro_sel  = gyro;
  endtask

  // random byte leaning toward the sign and magnitude edges
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // a burst with random content; cut short when len < BURST_BYTES
  task automatic send_burst(input logic mark_start, input int len);
    for (int i = 0; i < len; i++)
      send_byte(pick_byte(), (i == 0) ? mark_start : 1'b0);
  endtask

  // mostly whole bursts, with some broken ones and loose noise bytes
  task automatic run_random_bursts(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: begin
          // noise: random bytes with random frame marks
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            send_byte(pick_byte(), ($urandom_range(0, 3) == 0));
        end
        1: begin
          // broken burst: aborted partway, next one must resync
          len = $urandom_range(1, ibss_pkg::BURST_BYTES - 1);
          send_burst(1'b1, len);
        end
        default: begin
          // whole burst, frame mark sometimes left off and relying on the wrap
          len = ibss_pkg::BURST_BYTES;
          send_burst(($urandom_range(0, 3) != 0 || burst_pos != 0), len);
        end
      endcase
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one burst at reset ranges with the raw extremes on every channel kind
  task automatic test_extremes();
    logic [15:0] words[7];
    words = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001};
    for (int c = 0; c < 7; c++) begin
      send_byte(words[c][15:8], (c == 0));
      send_byte(words[c][7:0], 1'b0);
    end
  endtask

  // wrap into a new burst without a mark, then a frame mark mid-pair
  task automatic test_resync();
    send_byte(8'h00, 1'b0);   // byte 0 after the wrap
    send_byte(8'h00, 1'b0);   // accel x of the new burst
    send_byte(8'hA5, 1'b0);   // high byte of accel y, about to be dropped
    send_byte(8'h80, 1'b1);   // restart: becomes byte 0
    send_byte(8'h00, 1'b0);   // accel x = -32768
    send_byte(8'hC3, 1'b0);
    send_byte(8'h5A, 1'b0);   // accel y
  endtask

  // several range settings, extremes first, random stream under each
  task automatic test_range_phases();
    logic [1:0] accel_list[6];
    logic [1:0] gyro_list[6];
    accel_list = '{ACCEL_16G, ACCEL_4G, ACCEL_8G, ACCEL_16G, ACCEL_2G, ACCEL_2G};
    gyro_list  = '{GYRO_2000DPS, GYRO_1000DPS, GYRO_500DPS, GYRO_250DPS,
                   GYRO_2000DPS, GYRO_250DPS};
    for (int p = 0; p < 8; p++) begin
      drain_results();
      if (p < 6)
        set_ranges(accel_list[p], gyro_list[p]);
      else
        set_ranges(2'($urandom), 2'($urandom));
      // idling is switched off per side at random, so a phase may run without it
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      run_random_bursts(PHASE_ITEMS);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail();
    drain_results();
    set_ranges(2'($urandom), 2'($urandom));
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    run_random_bursts(TAIL_ITEMS);
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= ibss_pkg::REG_ACCEL_FS;
    cfg_data      <= 2'd0;
    in_valid      <= 1'b0;
    data_byte     <= 8'h00;
    frame_start   <= 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    accel_sel     = ACCEL_2G;
    gyro_sel      = GYRO_250DPS;
    burst_pos     = 0;
    high_byte     = 8'h00;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_resync();
    test_range_phases();
    test_full_rate_tail();
    drain_results();

    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
